// ===== hdl/ttwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ttwa_pkg - shared constants for the transaction slot table
// Table size, index widths, request kinds and status codes.
// ----------------------------------------------------------------------------
package ttwa_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int ID_W      = 32;
  localparam int BYTE_W    = 8;
  localparam int SLOT_OW   = 5;   // slot_index field width
  localparam int EXP_OW    = 6;   // expired_count field width

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_INSERT  = 2'd0;
  localparam req_t REQ_LOOKUP  = 2'd1;
  localparam req_t REQ_TICK    = 2'd2;
  localparam req_t REQ_CONFIRM = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_ZERO_ID   = 2'd3;

endpackage

// ===== hdl/transaction_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// transaction_table_with_aging - slot table with lifetime aging
// Insert / lookup / confirm / aging tick over a fixed table of slots.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the in_ stream: in_tuser carries the request kind
//    (insert, lookup, tick, confirm), in_tdata the id, hop count and lifetime.
//  - Every request gives exactly one result word on the out_ stream:
//    out_tuser carries the status, out_tdata the slot index, lookup data and
//    the number of slots expired by a tick.
//  - Each request sweeps all NUM_SLOTS slots through one shared compare /
//    decrement unit, one slot per cycle, behind a registered memory read.
//    An insert of id zero skips the sweep and goes straight to the finish
//    state.
//  - in_tready is high only while the sequencer is idle, so a new request
//    is not taken until the last result has entered the output register.
//  - The result sits in an output register; a new request may be accepted
//    while it waits. A stalled receiver holds the finished result in the
//    sequencer until the output register frees.
//  - Reset frees every slot at once (occupied and confirmed marks are flops);
//    no clearing pass is needed.
// ----------------------------------------------------------------------------
module transaction_table_with_aging
  import ttwa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: trans_id[31:0], hop_count[39:32], life_init[47:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: slot_index[4:0], hops_out[12:5], lifetime_out[20:13],
  //            confirmed_out[21], expired_count[27:22], zero pad[31:28]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [1:0]           state_r;

  // request held for the sweep
  req_t                 req_r;
  logic [ID_W-1:0]      id_r;
  logic [BYTE_W-1:0]    hops_in_r;
  logic [BYTE_W-1:0]    life_in_r;
  logic                 zero_id_r;

  // sweep: issue stage (address) and evaluate stage (data back)
  logic [IDX_W-1:0]     cnt_r;
  logic                 issue_r;
  logic                 s2_vld_r;
  logic [IDX_W-1:0]     s2_idx_r;

  // slot store
  logic [NUM_SLOTS-1:0] occ_r;    // slot holds a nonzero id
  logic [NUM_SLOTS-1:0] conf_r;
  logic [ID_W-1:0]      id_mem   [NUM_SLOTS];
  logic [BYTE_W-1:0]    hops_mem [NUM_SLOTS];
  logic [BYTE_W-1:0]    life_mem [NUM_SLOTS];
  logic [ID_W-1:0]      id_q_r;
  logic [BYTE_W-1:0]    hops_q_r;
  logic [BYTE_W-1:0]    life_q_r;

  // result being built
  logic                 hit_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic [BYTE_W-1:0]    res_hops_r;
  logic [BYTE_W-1:0]    res_life_r;
  logic                 res_conf_r;
  logic [CNT_W-1:0]     exp_cnt_r;

  // output register
  logic                 out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  status_t              out_user_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 s2_occ;
  logic                 s2_conf;
  logic                 id_match;
  logic                 do_ins;
  logic                 do_find;
  logic                 do_age;
  logic                 do_expire;
  logic                 do_dec;
  logic                 fin_load;
  status_t              fin_status;
  logic [IDX_W+SLOT_OW-1:0] idx_ext;
  logic [CNT_W+EXP_OW-1:0]  exp_ext;
  logic [OUT_DATA_W-1:0]    fin_data;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // evaluate stage: one slot per cycle
  assign s2_occ   = occ_r[s2_idx_r];
  assign s2_conf  = conf_r[s2_idx_r];
  assign id_match = s2_occ && (id_q_r == id_r);

  assign do_ins    = s2_vld_r && (req_r == REQ_INSERT) && !hit_r && !s2_occ;
  assign do_find   = s2_vld_r && (req_r inside {REQ_LOOKUP, REQ_CONFIRM})
                     && !hit_r && id_match;
  assign do_age    = s2_vld_r && (req_r == REQ_TICK) && s2_occ && !s2_conf;
  assign do_expire = do_age && (life_q_r == '0);
  assign do_dec    = do_age && (life_q_r != '0);

  assign fin_load  = (state_r == S_FIN) && out_free;

  always_comb begin
    case (req_r)
      REQ_INSERT:  fin_status = zero_id_r ? ST_ZERO_ID : (hit_r ? ST_OK : ST_FULL);
      REQ_LOOKUP,
      REQ_CONFIRM: fin_status = hit_r ? ST_OK : ST_NOT_FOUND;
      REQ_TICK:    fin_status = ST_OK;
      default:     fin_status = ST_OK;
    endcase
  end

  // fields truncate to their widths on wide tables
  assign idx_ext = {{SLOT_OW{1'b0}}, res_idx_r};
  assign exp_ext = {{EXP_OW{1'b0}}, exp_cnt_r};
  assign fin_data = {4'b0, exp_ext[EXP_OW-1:0], res_conf_r, res_life_r, res_hops_r,
                     idx_ext[SLOT_OW-1:0]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      issue_r   <= 1'b0;
      s2_vld_r  <= 1'b0;
      occ_r     <= '0;
      conf_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if ((in_tuser == REQ_INSERT) && (in_tdata[ID_W-1:0] == '0)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
              issue_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          s2_vld_r <= issue_r;
          if (issue_r && (cnt_r == LAST_IDX)) issue_r <= 1'b0;
          if (s2_vld_r && (s2_idx_r == LAST_IDX)) state_r <= S_FIN;
        end
        S_FIN: begin
          s2_vld_r <= 1'b0;
          if (fin_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // new result takes the output register, else it drains on tready
      if (fin_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (do_ins) begin
        occ_r[s2_idx_r]  <= 1'b1;
        conf_r[s2_idx_r] <= 1'b0;
      end
      if (do_find && (req_r == REQ_CONFIRM)) conf_r[s2_idx_r] <= 1'b1;
      if (do_expire) occ_r[s2_idx_r] <= 1'b0;
    end
  end

  // datapath and slot memories
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r      <= in_tuser;
      id_r       <= in_tdata[ID_W-1:0];
      hops_in_r  <= in_tdata[ID_W+BYTE_W-1:ID_W];
      life_in_r  <= in_tdata[ID_W+2*BYTE_W-1:ID_W+BYTE_W];
      zero_id_r  <= (in_tdata[ID_W-1:0] == '0);
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      res_idx_r  <= '0;
      res_hops_r <= '0;
      res_life_r <= '0;
      res_conf_r <= 1'b0;
      exp_cnt_r  <= '0;
    end else begin
      // issue: registered read, next address
      if ((state_r == S_SCAN) && issue_r) begin
        id_q_r   <= id_mem[cnt_r];
        hops_q_r <= hops_mem[cnt_r];
        life_q_r <= life_mem[cnt_r];
        s2_idx_r <= cnt_r;
        if (cnt_r != LAST_IDX) cnt_r <= cnt_r + 1'b1;
      end

      // evaluate: write back lags the read address by one slot
      if (do_ins) begin
        id_mem[s2_idx_r]   <= id_r;
        hops_mem[s2_idx_r] <= hops_in_r;
        life_mem[s2_idx_r] <= life_in_r;
        hit_r              <= 1'b1;
        res_idx_r          <= s2_idx_r;
      end
      if (do_find) begin
        hit_r     <= 1'b1;
        res_idx_r <= s2_idx_r;
        if (req_r == REQ_LOOKUP) begin
          res_hops_r <= hops_q_r;
          res_life_r <= life_q_r;
          res_conf_r <= s2_conf;
        end
      end
      if (do_dec) life_mem[s2_idx_r] <= life_q_r - 1'b1;
      if (do_expire) exp_cnt_r <= exp_cnt_r + 1'b1;
    end

    if (fin_load) begin
      out_data_r <= fin_data;
      out_user_r <= fin_status;
    end
  end

endmodule
